### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked property, held off while reset is high
`define EPSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("epsd assertion failed");
// checked property, live during reset too
`define EPSD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("epsd assertion failed");
`else
`define EPSD_ASSERT(lbl, clk, rst, prop)
`define EPSD_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### rtl/core/epsd_pkg.sv
package epsd_pkg;

  localparam logic [37:0] LAST_SECOND   = 38'd253402300799;
  localparam logic [37:0] SECS_PER_DAY  = 38'd86400;
  localparam logic [21:0] MARCH0_OFFSET = 22'd719468;
  localparam logic [21:0] CYCLE_DAYS    = 22'd146097;
  localparam logic [17:0] LAST_CYC_DAY  = 18'd146096;

  // x / d as (x * m) >> k, m = ceil(2^k / d), k = bits(x) + bits(d) keeps it exact
  // days from seconds: (secs >> 7) / 675
  localparam int          DAY_K   = 41;
  localparam logic [63:0] DAY_DIV = 64'd675;
  localparam logic [63:0] DAY_M   = ((64'd1 << DAY_K) + DAY_DIV - 64'd1) / DAY_DIV;

  localparam int          CYC_K = 40;
  localparam logic [63:0] CYC_M = ((64'd1 << CYC_K) + 64'd146096) / 64'd146097;

  localparam int          Q1460_K = 29;
  localparam logic [63:0] Q1460_M = ((64'd1 << Q1460_K) + 64'd1459) / 64'd1460;

  localparam int          Q36524_K = 34;
  localparam logic [63:0] Q36524_M = ((64'd1 << Q36524_K) + 64'd36523) / 64'd36524;

  localparam int          Q365_K = 27;
  localparam logic [63:0] Q365_M = ((64'd1 << Q365_K) + 64'd364) / 64'd365;

  localparam int          Q100_K = 16;
  localparam logic [63:0] Q100_M = ((64'd1 << Q100_K) + 64'd99) / 64'd100;

  localparam int          Q153_K = 19;
  localparam logic [63:0] Q153_M = ((64'd1 << Q153_K) + 64'd152) / 64'd153;

  localparam int          HR_K = 29;
  localparam logic [63:0] HR_M = ((64'd1 << HR_K) + 64'd3599) / 64'd3600;

  localparam int          MIN_K = 18;
  localparam logic [63:0] MIN_M = ((64'd1 << MIN_K) + 64'd59) / 64'd60;

  localparam logic [46:0] OUT_MIN = 47'd19700101000000;
  localparam logic [46:0] OUT_MAX = 47'd99991231235959;

  // first day-of-year of each month, year starting on march 1
  function automatic logic [8:0] month_start(input logic [3:0] mfm);
    logic [8:0] r;
    unique case (mfm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/epsd_daysplit.sv
module epsd_daysplit
  import epsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] epoch_seconds,
  output logic        day_valid,
  output logic [21:0] days,
  output logic [16:0] sod
);

  logic [2:0]  vld;
  logic [37:0] secs1;
  logic [37:0] secs2;
  logic [21:0] days2;
  logic [21:0] days3;
  logic [16:0] sod3;
  logic [DAY_K+21:0] d_prod;

  // 86400 = 128 * 675
  assign d_prod = (DAY_K + 22)'(secs1[37:7]) * (DAY_K + 22)'(DAY_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      secs1 <= (epoch_seconds > 64'(LAST_SECOND)) ? LAST_SECOND : epoch_seconds[37:0];
      days2 <= d_prod[DAY_K+21:DAY_K];
      secs2 <= secs1;
      days3 <= days2;
      sod3  <= 17'(secs2 - 38'(days2) * SECS_PER_DAY);
    end
  end

  assign day_valid = vld[2];
  assign days      = days3;
  assign sod       = sod3;

endmodule

### rtl/core/epsd_civil.sv
`include "assert_macros.svh"

module epsd_civil
  import epsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        day_valid,
  input  logic [21:0] days,
  output logic        date_valid,
  output logic [13:0] yr,
  output logic [3:0]  mo,
  output logic [4:0]  dy
);

  logic [7:0]  vld;
  logic [21:0] shifted1, shifted2;
  logic [4:0]  cyc2, cyc3, cyc4, cyc5;
  logic [17:0] dinc3, dinc4, dinc5;
  logic [17:0] t4;
  logic [8:0]  yinc5;
  logic [8:0]  dofy6, dofy7;
  logic [13:0] yrb6, yrb7;
  logic [3:0]  mfm7;
  logic [13:0] yr8;
  logic [3:0]  mo8;
  logic [4:0]  dy8;

  logic [CYC_K+4:0]    cyc_prod;
  logic [Q1460_K+6:0]  a_prod;
  logic [Q36524_K+2:0] b_prod;
  logic                c_last;
  logic [Q365_K+8:0]   y_prod;
  logic [Q100_K+1:0]   cent_prod;
  logic [17:0]         yday;
  logic [10:0]         mx;
  logic [Q153_K+3:0]   m_prod;

  assign cyc_prod = (CYC_K + 5)'(shifted1) * (CYC_K + 5)'(CYC_M);
  assign a_prod   = (Q1460_K + 7)'(dinc3) * (Q1460_K + 7)'(Q1460_M);
  assign b_prod   = (Q36524_K + 3)'(dinc3) * (Q36524_K + 3)'(Q36524_M);
  // only the last day of a 400-year cycle reaches 146096
  assign c_last   = (dinc3 == LAST_CYC_DAY);
  assign y_prod   = (Q365_K + 9)'(t4) * (Q365_K + 9)'(Q365_M);
  assign cent_prod = (Q100_K + 2)'(yinc5) * (Q100_K + 2)'(Q100_M);
  assign yday = 18'(yinc5) * 18'd365 + 18'(yinc5 >> 2)
              - 18'(cent_prod[Q100_K+1:Q100_K]);
  assign mx     = 11'(dofy6) * 11'd5 + 11'd2;
  assign m_prod = (Q153_K + 4)'(mx) * (Q153_K + 4)'(Q153_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], day_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shifted1 <= days + MARCH0_OFFSET;

      cyc2     <= cyc_prod[CYC_K+4:CYC_K];
      shifted2 <= shifted1;

      dinc3 <= 18'(shifted2 - 22'(cyc2) * CYCLE_DAYS);
      cyc3  <= cyc2;

      t4    <= dinc3 - 18'(a_prod[Q1460_K+6:Q1460_K])
             + 18'(b_prod[Q36524_K+2:Q36524_K]) - 18'(c_last);
      dinc4 <= dinc3;
      cyc4  <= cyc3;

      yinc5 <= y_prod[Q365_K+8:Q365_K];
      dinc5 <= dinc4;
      cyc5  <= cyc4;

      dofy6 <= 9'(dinc5 - yday);
      yrb6  <= 14'(yinc5) + 14'(cyc5) * 14'd400;

      mfm7  <= m_prod[Q153_K+3:Q153_K];
      dofy7 <= dofy6;
      yrb7  <= yrb6;

      // january and february belong to the next civil year
      dy8 <= 5'(dofy7 - month_start(mfm7) + 9'd1);
      mo8 <= (mfm7 < 4'd10) ? mfm7 + 4'd3 : mfm7 - 4'd9;
      yr8 <= yrb7 + 14'(mfm7 >= 4'd10);
    end
  end

  assign date_valid = vld[7];
  assign yr         = yr8;
  assign mo         = mo8;
  assign dy         = dy8;

  `EPSD_ASSERT(a_month_range, clk, rst, vld[7] |-> (mo8 >= 4'd1 && mo8 <= 4'd12))
  `EPSD_ASSERT(a_day_range, clk, rst, vld[7] |-> (dy8 >= 5'd1 && dy8 <= 5'd31))
  `EPSD_ASSERT(a_year_range, clk, rst, vld[7] |-> (yr8 >= 14'd1970 && yr8 <= 14'd9999))

endmodule

### rtl/core/epsd_tod.sv
module epsd_tod
  import epsd_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [16:0] sod,
  output logic [17:0] hms
);

  logic [4:0]  hh1, hh2, hh3, hh4;
  logic [16:0] sod1;
  logic [11:0] rem2, rem3;
  logic [5:0]  mm3, mm4;
  logic [5:0]  ss4;
  logic [17:0] tm5, tm6, tm7, tm8;

  logic [HR_K+4:0]  h_prod;
  logic [MIN_K+5:0] mm_prod;

  assign h_prod  = (HR_K + 5)'(sod) * (HR_K + 5)'(HR_M);
  assign mm_prod = (MIN_K + 6)'(rem2) * (MIN_K + 6)'(MIN_M);

  // payload only; the date path carries the valid bits at the same depth
  always_ff @(posedge clk) begin
    if (adv) begin
      hh1  <= h_prod[HR_K+4:HR_K];
      sod1 <= sod;

      rem2 <= 12'(sod1 - 17'(hh1) * 17'd3600);
      hh2  <= hh1;

      mm3  <= mm_prod[MIN_K+5:MIN_K];
      rem3 <= rem2;
      hh3  <= hh2;

      ss4  <= 6'(rem3 - 12'(mm3) * 12'd60);
      mm4  <= mm3;
      hh4  <= hh3;

      tm5  <= 18'(hh4) * 18'd10000 + 18'(mm4) * 18'd100 + 18'(ss4);
      tm6  <= tm5;
      tm7  <= tm6;
      tm8  <= tm7;
    end
  end

  assign hms = tm8;

endmodule

### rtl/core/epsd_pack.sv
module epsd_pack
  import epsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        date_valid,
  input  logic [13:0] yr,
  input  logic [3:0]  mo,
  input  logic [4:0]  dy,
  input  logic [17:0] hms,
  input  logic        out_stall,
  output logic        adv,
  output logic        out_valid,
  output logic [46:0] packed_datetime
);

  logic        v1;
  logic        v2;
  logic [26:0] date1;
  logic [17:0] tm1;
  logic [46:0] packed2;

  // whole pipe moves unless a finished beat sits stalled at the output
  assign adv = !(v2 && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= date_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      date1   <= 27'(yr) * 27'd10000 + 27'(mo) * 27'd100 + 27'(dy);
      tm1     <= hms;
      packed2 <= 47'(date1) * 47'd1000000 + 47'(tm1);
    end
  end

  assign out_valid       = v2;
  assign packed_datetime = packed2;

endmodule

### rtl/core/epoch_seconds_to_packed_date.sv
// channel   dir  handshake            payload
// input     in   in_valid/in_stall    epoch_seconds[63:0]
// output    out  out_valid/out_stall  packed_datetime[46:0]
//
// one beat per cycle while no stalled output beat holds the pipe
// depth is set by the reciprocal-multiply divides
// synchronous reset clears only the valid bits
// out_stall on a valid output beat freezes every stage at once; in_stall follows a stalled output beat
`include "assert_macros.svh"

module epoch_seconds_to_packed_date
  import epsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [46:0] packed_datetime
);

  logic        adv;
  logic        day_valid;
  logic [21:0] days;
  logic [16:0] sod;
  logic        date_valid;
  logic [13:0] yr;
  logic [3:0]  mo;
  logic [4:0]  dy;
  logic [17:0] hms;

  assign in_stall = !adv;

  epsd_daysplit u_daysplit (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (in_valid),
    .epoch_seconds (epoch_seconds),
    .day_valid     (day_valid),
    .days          (days),
    .sod           (sod)
  );

  epsd_civil u_civil (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .day_valid  (day_valid),
    .days       (days),
    .date_valid (date_valid),
    .yr         (yr),
    .mo         (mo),
    .dy         (dy)
  );

  epsd_tod u_tod (
    .clk (clk),
    .adv (adv),
    .sod (sod),
    .hms (hms)
  );

  epsd_pack u_pack (
    .clk             (clk),
    .rst             (rst),
    .date_valid      (date_valid),
    .yr              (yr),
    .mo              (mo),
    .dy              (dy),
    .hms             (hms),
    .out_stall       (out_stall),
    .adv             (adv),
    .out_valid       (out_valid),
    .packed_datetime (packed_datetime)
  );

  `EPSD_ASSERT(a_out_not_above, clk, rst, out_valid |-> packed_datetime <= OUT_MAX)
  `EPSD_ASSERT(a_out_not_below, clk, rst, out_valid |-> packed_datetime >= OUT_MIN)
  `EPSD_ASSERT_NR(a_rst_clears_out, clk, rst |=> !out_valid)

endmodule

### verif/epoch_seconds_to_packed_date_tb.sv
module epoch_seconds_to_packed_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epsd_pkg::*;

  typedef struct packed {
    logic        typed;
    logic [63:0] secs;
    logic [46:0] want;
  } date_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [46:0] packed_datetime;

  logic [46:0] due_stamps [$];
  logic [46:0] want_stamp;
  int unsigned fault_count = 0;
  logic        steady = 1'b0;

  // typed rows cover the lowest inputs and the saturation region
  date_row_t date_rows [22] = '{
    '{1'b1, 64'd0,                   OUT_MIN},
    '{1'b1, 64'd86399,               47'd19700101235959},
    '{1'b0, 64'd86400,               '0},
    '{1'b0, 64'd59,                  '0},
    '{1'b0, 64'd3599,                '0},
    '{1'b0, 64'd3600,                '0},
    '{1'b0, 64'd946684799,           '0},  // last second of 1999
    '{1'b0, 64'd951782399,           '0},  // into leap day 2000
    '{1'b0, 64'd951868799,           '0},  // leap day into march
    '{1'b0, 64'd4107542399,          '0},  // 2100 is not a leap year
    '{1'b0, 64'd2147483647,          '0},
    '{1'b0, 64'd4294967295,          '0},
    '{1'b0, 64'd4294967296,          '0},
    '{1'b0, 64'd253402214400,        '0},  // start of the last day
    '{1'b0, 64'd253402300798,        '0},
    '{1'b1, 64'(LAST_SECOND),        OUT_MAX},
    '{1'b1, 64'd253402300800,        OUT_MAX},
    '{1'b1, 64'd274877906943,        OUT_MAX},
    '{1'b1, 64'h5555_5555_5555_5555, OUT_MAX},
    '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, OUT_MAX},
    '{1'b1, 64'h8000_0000_0000_0000, OUT_MAX},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, OUT_MAX}
  };

  epoch_seconds_to_packed_date u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .epoch_seconds   (epoch_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .packed_datetime (packed_datetime)
  );

  always #4 clk = ~clk;

  function automatic logic [46:0] civil_stamp_of(input logic [63:0] secs);
    logic [63:0] s, days, sod, shifted, cyc, dinc, yinc, dofy, mfm;
    logic [63:0] yr, mo, dy, hh, mi, ss;
    s = (secs > 64'(LAST_SECOND)) ? 64'(LAST_SECOND) : secs;
    days = s / 64'(SECS_PER_DAY);
    sod = s % 64'(SECS_PER_DAY);
    // day count from march 1 of year zero, split into 400-year eras
    shifted = days + 64'(MARCH0_OFFSET);
    cyc = shifted / 64'(CYCLE_DAYS);
    dinc = shifted - cyc * 64'(CYCLE_DAYS);
    yinc = (dinc - dinc / 64'd1460 + dinc / 64'd36524 - dinc / 64'(LAST_CYC_DAY)) / 64'd365;
    dofy = dinc - (64'd365 * yinc + yinc / 64'd4 - yinc / 64'd100);
    mfm = (64'd5 * dofy + 64'd2) / 64'd153;
    dy = dofy - (64'd153 * mfm + 64'd2) / 64'd5 + 64'd1;
    mo = (mfm < 64'd10) ? mfm + 64'd3 : mfm - 64'd9;
    yr = yinc + cyc * 64'd400 + ((mo <= 64'd2) ? 64'd1 : 64'd0);
    hh = sod / 64'd3600;
    mi = (sod - hh * 64'd3600) / 64'd60;
    ss = sod - hh * 64'd3600 - mi * 64'd60;
    return 47'(yr * 64'd10000000000 + mo * 64'd100000000 + dy * 64'd1000000 +
               hh * 64'd10000 + mi * 64'd100 + ss);
  endfunction

  function automatic logic [63:0] pick_seconds();
    logic [63:0] day;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {$urandom, $urandom} % (64'(LAST_SECOND) + 64'd1);
      5, 6: begin
        // a few seconds either side of midnight on a random day
        day = 64'($urandom_range(1, 2932896));
        return day * 64'(SECS_PER_DAY) - 64'd3 + 64'($urandom_range(0, 5));
      end
      7: return 64'(LAST_SECOND) - 64'd5 + 64'($urandom_range(0, 10));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_fault(input string what, input logic [46:0] want,
                            input logic [46:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic offer_seconds(input logic [63:0] secs, input logic [46:0] stamp);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    due_stamps.push_back(stamp);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_stamps.size() != 0);
  endtask

  task automatic run_random(input int unsigned count);
    logic [63:0] secs;
    repeat (count) begin
      secs = pick_seconds();
      offer_seconds(secs, civil_stamp_of(secs));
    end
  endtask

  // receiver: random stall before each beat unless steady is set
  initial begin
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_stamps.size() == 0) begin
        note_fault("beat with nothing expected", '0, packed_datetime);
      end else begin
        want_stamp = due_stamps.pop_front();
        if (packed_datetime !== want_stamp)
          note_fault("packed_datetime mismatch", want_stamp, packed_datetime);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (date_rows[i])
      offer_seconds(date_rows[i].secs, date_rows[i].typed ? date_rows[i].want
                                                          : civil_stamp_of(date_rows[i].secs));
    drain_results();

    run_random(260);
    drain_results();
    steady = 1'b1;
    run_random(80);
    steady = 1'b0;
    run_random(260);
    drain_results();

    repeat (40) @(posedge clk);
    if (fault_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
